// File: rtl/adv_name_filter_device_table_assert.svh
// Assertion macros shared by the checker.
`ifndef ADV_NAME_FILTER_DEVICE_TABLE_ASSERT_SVH
`define ADV_NAME_FILTER_DEVICE_TABLE_ASSERT_SVH
`define ANF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ANF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/anf_pkg.sv
package anf_pkg;
   localparam int TABLE_ENTRIES = 16;
   localparam int NAME_LEN = 32;
   localparam logic [1:0] REQ_ADV   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [2:0] ST_NONAME   = 3'd0;
   localparam logic [2:0] ST_MISMATCH = 3'd1;
   localparam logic [2:0] ST_UPDATED  = 3'd2;
   localparam logic [2:0] ST_ADDED    = 3'd3;
   localparam logic [2:0] ST_REPLACED = 3'd4;
   localparam logic [2:0] ST_READ     = 3'd5;
   localparam logic [2:0] ST_CLEARED  = 3'd6;
   localparam logic [7:0] TYPE_NAME_FULL  = 8'h09;
   localparam logic [7:0] TYPE_NAME_SHORT = 8'h08;
   localparam logic [23:0] PREFIX_RESET = 24'h415453;
endpackage

// File: rtl/anf_parser.sv
module anf_parser (
   input  logic clock,
   input  logic reset,
   input  logic byte_en,
   input  logic restart,
   input  logic [7:0] adv_byte,
   output logic name_found,
   output logic [$clog2(anf_pkg::NAME_LEN)-1:0] cap_len,
   output logic [7:0] stage_rd [3],
   input  logic [$clog2(anf_pkg::NAME_LEN)-1:0] stage_ra,
   output logic [7:0] stage_rq
);
   import anf_pkg::*;
   localparam int LW = $clog2(NAME_LEN);
   typedef enum logic [1:0] {PH_LEN, PH_TYPE, PH_DATA, PH_DONE} phase_type;
   phase_type phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic found_ff, found_in;
   logic [LW-1:0] len_ff, len_in;
   logic wr;
   logic [7:0] stage_ff [NAME_LEN];

   always_comb begin
      phase_in = phase_ff; left_in = left_ff; found_in = found_ff; len_in = len_ff;
      wr = 1'b0;
      case (phase_ff)
         PH_LEN: begin
            if (adv_byte == 8'd0) phase_in = PH_DONE;
            else begin
               left_in = adv_byte - 8'd1; phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (adv_byte == TYPE_NAME_FULL || adv_byte == TYPE_NAME_SHORT) begin
               found_in = 1'b1; len_in = '0;
               phase_in = (left_ff == 8'd0) ? PH_DONE : PH_DATA;
            end else phase_in = (left_ff == 8'd0) ? PH_LEN : PH_DATA;
         end
         PH_DATA: begin
            if (found_ff && (len_ff < LW'(NAME_LEN-1))) begin
               wr = 1'b1; len_in = len_ff + 1'b1;
            end
            left_in = left_ff - 8'd1;
            if (left_in == 8'd0) phase_in = found_ff ? PH_DONE : PH_LEN;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff <= PH_LEN; left_ff <= '0; found_ff <= 1'b0; len_ff <= '0;
      end else if (byte_en) begin
         phase_ff <= phase_in; left_ff <= left_in; found_ff <= found_in; len_ff <= len_in;
      end
      if (byte_en && wr) stage_ff[len_ff] <= adv_byte;
   end

   assign name_found = found_ff;
   assign cap_len = len_ff;
   assign stage_rd[0] = stage_ff[0];
   assign stage_rd[1] = stage_ff[1];
   assign stage_rd[2] = stage_ff[2];
   assign stage_rq = stage_ff[stage_ra];
endmodule

// File: rtl/adv_name_filter_device_table.sv
// A mid-report byte is taken with no result and leaves the block idle, so bytes may follow back to back.
// Busy states: a clear S_OUT; a read S_READ, S_OUT; a rejected report S_DECIDE, S_OUT; an
// accepted report S_DECIDE, S_SCAN and S_SCANW per entry, S_DECIDE, S_NAME, S_READ, S_OUT.
// rsp_strobe marks the result in the same cycle that busy falls; the receiver cannot stall.
// Synchronous active-high reset empties the table and restarts the parser.
module adv_name_filter_device_table (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_type,
   input  logic [7:0] req_adv_byte,
   input  logic req_report_last,
   input  logic [47:0] req_dev_addr,
   input  logic signed [7:0] req_signal_level,
   input  logic [31:0] req_now_ms,
   input  logic [3:0] req_entry_sel,
   input  logic [4:0] req_name_pos,
   input  logic csr_write,
   input  logic [23:0] csr_wdata,
   output logic rsp_strobe,
   output logic [2:0] rsp_status,
   output logic [3:0] rsp_entry_index,
   output logic [47:0] rsp_entry_addr,
   output logic signed [7:0] rsp_entry_level,
   output logic [31:0] rsp_entry_seen,
   output logic [7:0] rsp_name_byte,
   output logic [4:0] rsp_entry_count
);
   import anf_pkg::*;
   localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int LW = $clog2(NAME_LEN);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SCANW, S_DECIDE, S_NAME, S_READ, S_OUT}
      state_type;

   logic [47:0] addr_mem [TABLE_ENTRIES];
   logic [7:0]  lvl_mem  [TABLE_ENTRIES];
   logic [31:0] seen_mem [TABLE_ENTRIES];
   logic [7:0]  name_mem [TABLE_ENTRIES*NAME_LEN];
   logic [47:0] addr_q; logic [7:0] lvl_q; logic [31:0] seen_q; logic [7:0] name_q;

   state_type st_ff;
   logic [23:0] prefix_ff;
   logic [CW-1:0] count_ff;
   logic [EW-1:0] ra_ff, idx_ff, old_ff;
   logic [CW-1:0] scan_ff;
   logic [31:0] oage_ff;
   logic hit_ff;
   logic [LW-1:0] npos_ff;
   logic [47:0] addr_ff; logic [7:0] lvl_ff; logic [31:0] now_ff;
   logic [4:0] pos_ff; logic [3:0] sel_ff; logic zero_ff;
   logic [2:0] status_ff;
   logic strobe_ff;

   logic name_found;
   logic [LW-1:0] cap_len;
   logic [7:0] stage_rd [3];
   logic [7:0] stage_rq;
   logic byte_en, restart;
   logic [31:0] age;
   logic [LW-1:0] nidx;
   logic nwr;
   logic [7:0] nwd;

   // The parser is restarted only in S_OUT, once the report has been judged and, if accepted, its name copied.
   logic report_ff;

   assign byte_en = start && !busy && req_type == REQ_ADV;
   assign restart = st_ff == S_OUT && report_ff;
   assign nidx = npos_ff;
   assign nwr = st_ff == S_NAME;
   assign nwd = (nidx < cap_len) ? stage_rq : 8'd0;

   anf_parser u_parser (
      .clock, .reset, .byte_en, .restart, .adv_byte(req_adv_byte),
      .name_found, .cap_len, .stage_rd, .stage_ra(nidx), .stage_rq);

   // Parser state is read combinationally before restart so the report can be judged.
   logic found_c; logic [LW-1:0] len_c; logic [7:0] s0, s1, s2;
   logic pass;
   always_comb begin
      found_c = name_found; len_c = cap_len;
      s0 = stage_rd[0]; s1 = stage_rd[1]; s2 = stage_rd[2];
   end
   assign pass = found_c && len_c >= LW'(3) && s0 == prefix_ff[23:16]
                 && s1 == prefix_ff[15:8] && s2 == prefix_ff[7:0];

   // Judging runs in the cycle after the final byte, once the parser has taken it.
   logic judge_ff;
   assign age = now_ff - seen_q;

   logic [EW-1:0] widx;
   always_comb widx = hit_ff ? idx_ff : (count_ff < CW'(TABLE_ENTRIES) ?
                      EW'(count_ff) : old_ff);

   always_ff @(posedge clock) begin
      addr_q <= addr_mem[ra_ff]; lvl_q <= lvl_mem[ra_ff]; seen_q <= seen_mem[ra_ff];
      name_q <= name_mem[{ra_ff, pos_ff[LW-1:0]}];
      if (st_ff == S_DECIDE && !judge_ff) begin
         addr_mem[widx] <= addr_ff; lvl_mem[widx] <= lvl_ff; seen_mem[widx] <= now_ff;
      end
      if (nwr) name_mem[{idx_ff, nidx}] <= nwd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; prefix_ff <= PREFIX_RESET; count_ff <= '0; strobe_ff <= 1'b0;
         judge_ff <= 1'b0; report_ff <= 1'b0;
      end else begin
         strobe_ff <= st_ff == S_OUT;
         if (csr_write) prefix_ff <= csr_wdata;
         case (st_ff)
            S_IDLE: begin
               if (start) begin
                  addr_ff <= req_dev_addr; lvl_ff <= req_signal_level; now_ff <= req_now_ms;
                  pos_ff <= req_name_pos; sel_ff <= req_entry_sel;
                  case (req_type)
                     REQ_ADV: if (req_report_last) begin
                        judge_ff <= 1'b1; st_ff <= S_DECIDE; report_ff <= 1'b1;
                     end
                     REQ_READ: begin
                        ra_ff <= EW'(req_entry_sel);
                        zero_ff <= !({1'b0, req_entry_sel} < 5'(count_ff)) ||
                                   (32'(req_entry_sel) >= TABLE_ENTRIES);
                        status_ff <= ST_READ;
                        st_ff <= S_READ;
                     end
                     REQ_CLEAR: begin
                        count_ff <= '0; status_ff <= ST_CLEARED; zero_ff <= 1'b1;
                        st_ff <= S_OUT;
                     end
                     default: ;
                  endcase
               end
            end
            S_DECIDE: begin
               if (judge_ff) begin
                  judge_ff <= 1'b0;
                  if (!found_c || !pass) begin
                     status_ff <= found_c ? ST_MISMATCH : ST_NONAME;
                     zero_ff <= 1'b1; st_ff <= S_OUT;
                  end else begin
                     hit_ff <= 1'b0; scan_ff <= '0; ra_ff <= '0; oage_ff <= '0;
                     old_ff <= '0; st_ff <= (count_ff == '0) ? S_DECIDE : S_SCAN;
                  end
               end else begin
                  idx_ff <= widx;
                  status_ff <= hit_ff ? ST_UPDATED :
                     (count_ff < CW'(TABLE_ENTRIES) ? ST_ADDED : ST_REPLACED);
                  if (!hit_ff && count_ff < CW'(TABLE_ENTRIES)) count_ff <= count_ff + 1'b1;
                  npos_ff <= '0; st_ff <= S_NAME;
               end
            end
            S_SCAN: st_ff <= S_SCANW;
            S_SCANW: begin
               if (addr_q == addr_ff) begin
                  hit_ff <= 1'b1; idx_ff <= ra_ff; st_ff <= S_DECIDE;
               end else begin
                  if (age > oage_ff) begin
                     oage_ff <= age; old_ff <= ra_ff;
                  end
                  if (scan_ff + 1'b1 >= count_ff) st_ff <= S_DECIDE;
                  else begin
                     st_ff <= S_SCAN;
                  end
                  scan_ff <= scan_ff + 1'b1; ra_ff <= ra_ff + 1'b1;
               end
            end
            S_NAME: begin
               npos_ff <= npos_ff + 1'b1;
               if (npos_ff == LW'(NAME_LEN-1)) begin
                  ra_ff <= idx_ff; zero_ff <= 1'b0; st_ff <= S_READ;
               end
            end
            S_READ: st_ff <= S_OUT;
            S_OUT: begin
               report_ff <= 1'b0; st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = st_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_entry_index = (status_ff == ST_READ) ? sel_ff :
                            (zero_ff ? 4'd0 : 4'(idx_ff));
   assign rsp_entry_addr = zero_ff ? '0 : addr_q;
   assign rsp_entry_level = zero_ff ? '0 : lvl_q;
   assign rsp_entry_seen = zero_ff ? '0 : seen_q;
   assign rsp_name_byte = (zero_ff || 32'(pos_ff) >= NAME_LEN) ? 8'd0 : name_q;
   assign rsp_entry_count = 5'(count_ff);
endmodule

// File: rtl/anf_checker.sv
`include "adv_name_filter_device_table_assert.svh"
module anf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic [1:0] req_type,
   input logic rsp_strobe,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_entry_count
);
   import anf_pkg::*;
   `ANF_ASSERT_IMPL(a_stat, clock, reset, rsp_strobe, rsp_status <= ST_CLEARED)
   `ANF_ASSERT_IMPL(a_clr, clock, reset, rsp_strobe && rsp_status == ST_CLEARED,
      rsp_entry_count == 5'd0)
   `ANF_ASSERT_NEXT(a_busy, clock, reset, start && !busy && req_type == REQ_READ, busy)
   `ANF_ASSERT_NEXT(a_one, clock, reset, rsp_strobe, !rsp_strobe)
endmodule

bind adv_name_filter_device_table anf_checker u_anf_checker (.*);
